FILE: hdl/i2cbb_pkg.sv
// Shared types, codes and reset constants for the I2C bit-bang master.
package i2cbb_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
  localparam logic [9:0]  ACK_TIMEOUT_RST = 10'd250;

  localparam logic [7:0]  MSB_MASK = 8'h80;

  // Configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // Command codes
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_WACK  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       ready;
    logic       done;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage

FILE: hdl/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: input register, sequencer, result register.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o | cmd_valid, func, write_byte, send_ack, sda_level
//  out     | out_valid_o/out_ready_i | scl, sda_out, sda_oe, ready_res, done_res,
//          |                        | read_data, ack_missing
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_data_i (phase_ticks, ack_timeout)
//
//  One word per cycle sustained while the output is not stalled; a word's result is on the outputs
//  after acceptance, through the input register and then the sequencer step into the result register,
//  and can be taken at the following edge.
//  Reset puts the sequencer idle with SCL and SDA high and the config at 50 / 250 ticks.
//  A stalled output holds the result register and, once the input register is full,
//  drops in_ready_o; no word is lost or repeated.
module i2c_bitbang_master
  import i2cbb_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [2:0]  func_i,
  input  logic [7:0]  write_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_out_o,
  output logic        sda_oe_o,
  output logic        ready_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_missing_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_vld_q;
  item_t       item_q;
  logic        out_vld_q;
  res_t        res_q;
  res_t        res;
  logic        advance;
  logic        fire;
  logic        accept;
  logic [15:0] phase_ticks;
  logic [9:0]  ack_timeout;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd_valid  <= cmd_valid_i;
      item_q.func       <= func_i;
      item_q.write_byte <= write_byte_i;
      item_q.send_ack   <= send_ack_i;
      item_q.sda_level  <= sda_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  i2cbb_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .phase_ticks_o (phase_ticks),
    .ack_timeout_o (ack_timeout)
  );

  i2cbb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item_q),
    .phase_ticks_i (phase_ticks),
    .ack_timeout_i (ack_timeout),
    .res_o         (res)
  );

  assign out_valid_o   = out_vld_q;
  assign scl_o         = res_q.scl;
  assign sda_out_o     = res_q.sda_out;
  assign sda_oe_o      = res_q.sda_oe;
  assign ready_res_o   = res_q.ready;
  assign done_res_o    = res_q.done;
  assign read_data_o   = res_q.read_data;
  assign ack_missing_o = res_q.ack_missing;

endmodule

FILE: hdl/i2cbb_cfg.sv
// Configuration registers: SCL half-phase length and ack timeout.
module i2cbb_cfg
  import i2cbb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic [15:0] phase_ticks_o,
  output logic [9:0]  ack_timeout_o
);

  logic [15:0] phase_q;
  logic [9:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_TICKS_RST;
      timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_TICKS: phase_q   <= cfg_data_i;
        REG_ACK_TIMEOUT: timeout_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign phase_ticks_o = phase_q;
  assign ack_timeout_o = timeout_q;

endmodule

FILE: hdl/i2cbb_core.sv
// Bus sequencer: state registers and the per-tick next-state logic.
module i2cbb_core
  import i2cbb_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  input  logic [15:0] phase_ticks_i,
  input  logic [9:0]  ack_timeout_i,
  output res_t        res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ST_A, S_ST_B, S_SP_A, S_SP_B, S_WR_SET, S_WR_HI, S_WR_LO,
    S_WA_SET, S_WA_HI, S_WA_POLL, S_RD_LO, S_RD_HI, S_AK_LO, S_AK_HI
  } state_e;

  state_e                 state_q, state_d;
  logic [3:0]             bit_q, bit_d;
  logic [COUNT_WIDTH-1:0] phase_q, phase_d;
  logic [9:0]             wait_q, wait_d;
  logic [7:0]             shift_q, shift_d;
  logic                   ackc_q, ackc_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   err_q, err_d;
  logic [7:0]             rx_q, rx_d;

  logic [COUNT_WIDTH-1:0] plen_raw, plen, cnt_inc, cnt_ticked;
  logic                   ph_end;
  logic [3:0]             bit_inc;
  logic                   done;
  logic                   oe;

  assign plen_raw   = COUNT_WIDTH'(phase_ticks_i);
  assign plen       = (plen_raw == '0) ? COUNT_WIDTH'(1) : plen_raw;
  assign cnt_inc    = phase_q + COUNT_WIDTH'(1);
  assign ph_end     = (cnt_inc >= plen);
  assign cnt_ticked = ph_end ? '0 : cnt_inc;
  assign bit_inc    = bit_q + 4'd1;

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    phase_d = phase_q;
    wait_d  = wait_q;
    shift_d = shift_q;
    ackc_d  = ackc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    rx_d    = rx_q;
    done    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_i.cmd_valid) begin
          unique case (item_i.func)
            FUNC_START: begin
              sda_d = 1'b1; scl_d = 1'b1; state_d = S_ST_A; phase_d = '0;
            end
            FUNC_STOP: begin
              scl_d = 1'b0; sda_d = 1'b0; state_d = S_SP_A; phase_d = '0;
            end
            FUNC_WRITE: begin
              shift_d = item_i.write_byte; bit_d = 4'd0; scl_d = 1'b0;
              sda_d   = |(item_i.write_byte & MSB_MASK);
              state_d = S_WR_SET; phase_d = '0;
            end
            FUNC_WACK: begin
              err_d = 1'b0; wait_d = '0; sda_d = 1'b1;
              state_d = S_WA_SET; phase_d = '0;
            end
            FUNC_READ: begin
              ackc_d = item_i.send_ack; bit_d = 4'd0; shift_d = '0;
              sda_d = 1'b1; scl_d = 1'b0; state_d = S_RD_LO; phase_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_ST_A: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          sda_d = 1'b0; state_d = S_ST_B;
        end
      end
      S_ST_B: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b0; state_d = S_IDLE; done = 1'b1;
        end
      end
      S_SP_A: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b1; state_d = S_SP_B;
        end
      end
      S_SP_B: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          sda_d = 1'b1; state_d = S_IDLE; done = 1'b1;
        end
      end
      S_WR_SET: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b1; state_d = S_WR_HI;
        end
      end
      S_WR_HI: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b0; state_d = S_WR_LO;
        end
      end
      S_WR_LO: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          bit_d   = bit_inc;
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            state_d = S_IDLE; done = 1'b1;
          end else begin
            sda_d   = shift_q[6];
            state_d = S_WR_SET;
          end
        end
      end
      S_WA_SET: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b1; state_d = S_WA_HI;
        end
      end
      S_WA_HI: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          state_d = S_WA_POLL;
        end
      end
      S_WA_POLL: begin
        if (!item_i.sda_level) begin
          scl_d = 1'b0; state_d = S_IDLE; phase_d = '0; done = 1'b1;
        end else if (wait_q >= ack_timeout_i) begin
          err_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          state_d = S_SP_A; phase_d = '0;
        end else begin
          wait_d = wait_q + 10'd1;
        end
      end
      S_RD_LO: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b1; state_d = S_RD_HI;
        end
      end
      S_RD_HI: begin
        if (phase_q == '0) begin
          shift_d = {shift_q[6:0], item_i.sda_level};
        end
        phase_d = cnt_ticked;
        if (ph_end) begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc >= 4'd8) begin
            rx_d    = shift_d;
            sda_d   = !ackc_q;
            state_d = S_AK_LO;
          end else begin
            state_d = S_RD_LO;
          end
        end
      end
      S_AK_LO: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b1; state_d = S_AK_HI;
        end
      end
      S_AK_HI: begin
        phase_d = cnt_ticked;
        if (ph_end) begin
          scl_d = 1'b0; state_d = S_IDLE; done = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE; phase_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
      phase_q <= '0;
      wait_q  <= '0;
      shift_q <= '0;
      ackc_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      err_q   <= 1'b0;
      rx_q    <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      shift_q <= shift_d;
      ackc_q  <= ackc_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      err_q   <= err_d;
      rx_q    <= rx_d;
    end
  end

  // SDA released while waiting for the ack and during the read bits
  assign oe = !(state_d == S_WA_SET || state_d == S_WA_HI || state_d == S_WA_POLL ||
                state_d == S_RD_LO || state_d == S_RD_HI);

  always_comb begin
    res_o.scl         = scl_d;
    res_o.sda_out     = oe ? sda_d : 1'b1;
    res_o.sda_oe      = oe;
    res_o.ready       = (state_d == S_IDLE);
    res_o.done        = done;
    res_o.read_data   = rx_d;
    res_o.ack_missing = err_d;
  end

  a_hold_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(state_q) && $stable(phase_q) && $stable(bit_q))
    else $error("sequencer state moved without a word");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && state_q == S_IDLE && !item_i.cmd_valid |=> state_q == S_IDLE)
    else $error("left idle without a command");

  a_err_from_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> $past(state_q) == S_WA_POLL && state_q == S_SP_A)
    else $error("ack_missing raised outside ack poll");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.done |=> bit_q <= 4'd8 && state_q == S_IDLE)
    else $error("completion left sequencer busy");

endmodule
